// File: rtl/core/arm_pkg.sv
// Shared types, constants and the CORDIC gain function for the rotation matrix builder.
`timescale 1ns / 1ps
package arm_pkg;

  localparam int CordicSteps = 16;
  localparam int FracBits    = 14;
  localparam int TableLen    = 24;
  localparam int AngW        = 35;
  localparam int CorW        = 33;

  localparam logic signed [AngW-1:0] Q30Pi     = 35'sd3373259426;
  localparam logic signed [AngW-1:0] Q30TwoPi  = 35'sd6746518852;
  localparam logic signed [AngW-1:0] Q30HalfPi = 35'sd1686629713;

  localparam logic signed [CorW-1:0] AtanQ30 [TableLen] = '{
    33'sh3243F6A8, 33'sh1DAC6705, 33'sh0FADBAFC, 33'sh07F56EA6, 33'sh03FEAB76,
    33'sh01FFD55B, 33'sh00FFFAAA, 33'sh007FFF55, 33'sh003FFFEA, 33'sh001FFFFD,
    33'sh000FFFFF, 33'sh0007FFFF, 33'sh0003FFFF, 33'sh0001FFFF, 33'sh0000FFFF,
    33'sh00007FFF, 33'sh00003FFF, 33'sh00001FFF, 33'sh00000FFF, 33'sh000007FF,
    33'sh000003FF, 33'sh000001FF, 33'sh000000FF, 33'sh0000007F
  };

  // One CORDIC cell's worth of state, with the axis carried alongside.
  typedef struct packed {
    logic                   vld;
    logic signed [CorW-1:0] x;
    logic signed [CorW-1:0] y;
    logic signed [CorW-1:0] z;
    logic                   neg;
    logic signed [15:0]     ax;
    logic signed [15:0]     ay;
    logic signed [15:0]     az;
  } cordic_t;

  // Starting x of the CORDIC: the integer gain in Q30, evaluated at elaboration.
  function automatic logic signed [CorW-1:0] cordic_gain(int n);
    logic [63:0] k2;
    logic [63:0] d;
    logic [63:0] q;
    logic [63:0] r;
    logic [63:0] rem;
    logic [63:0] res;
    logic [63:0] bitv;
    k2 = 64'd1 << 30;
    for (int i = 0; i < TableLen; i++) begin
      if (i < n) begin
        d = (64'd1 << (2 * i)) + 64'd1;
        // Long division of k2 by d, one quotient bit per pass.
        q = '0;
        r = '0;
        for (int b = 63; b >= 0; b--) begin
          r = {r[62:0], k2[b]};
          if (r >= d) begin
            r    = r - d;
            q[b] = 1'b1;
          end
        end
        k2 = k2 - q;
      end
    end
    rem  = k2 << 30;
    res  = '0;
    bitv = 64'd1 << 62;
    for (int j = 0; j < 32; j++) begin
      if (rem >= res + bitv) begin
        rem = rem - (res + bitv);
        res = (res >> 1) + bitv;
      end else begin
        res = res >> 1;
      end
      bitv = bitv >> 2;
    end
    return CorW'(res);
  endfunction

endpackage

// File: rtl/core/arm_cordic_cell.sv
// One rotation step of the CORDIC chain, registered.
`timescale 1ns / 1ps
module arm_cordic_cell #(
  parameter int STEP = 0
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             en,
  input  arm_pkg::cordic_t din,
  output arm_pkg::cordic_t dout
);

  arm_pkg::cordic_t nxt;

  // Rotate toward zero residual angle.
  always_comb begin
    nxt = din;
    if (!din.z[arm_pkg::CorW-1]) begin
      nxt.x = din.x - (din.y >>> STEP);
      nxt.y = din.y + (din.x >>> STEP);
      nxt.z = din.z - arm_pkg::AtanQ30[STEP];
    end else begin
      nxt.x = din.x + (din.y >>> STEP);
      nxt.y = din.y - (din.x >>> STEP);
      nxt.z = din.z + arm_pkg::AtanQ30[STEP];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dout <= nxt;
    end
    if (rst) begin
      dout.vld <= 1'b0;
    end
  end

endmodule

// File: rtl/core/arm_matrix.sv
// Three-stage product and sum pipeline that forms the nine rotation entries.
`timescale 1ns / 1ps
module arm_matrix #(
  parameter int FRAC_BITS = arm_pkg::FracBits
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             en,
  input  arm_pkg::cordic_t din,
  output logic             vld,
  output logic [15:0]      ent [9]
);

  localparam int Sh  = 30 - FRAC_BITS;
  localparam int CW  = FRAC_BITS + 3;
  localparam int MW  = FRAC_BITS + 36;
  localparam int RSh = 14 + FRAC_BITS;

  logic signed [arm_pkg::CorW-1:0] xneg;
  logic signed [arm_pkg::CorW-1:0] xr;
  logic signed [arm_pkg::CorW-1:0] yr;
  logic signed [CW-1:0] c_in;
  logic signed [CW-1:0] s_in;

  // Round cosine and sine half up to the working fraction.
  always_comb begin
    xneg = din.neg ? -din.x : din.x;
    xr   = (xneg + (33'sd1 <<< (Sh - 1))) >>> Sh;
    yr   = (din.y + (33'sd1 <<< (Sh - 1))) >>> Sh;
    c_in = CW'(xr);
    s_in = CW'(yr);
  end

  // Stage A: axis products and sine products.
  logic              va;
  logic signed [31:0] xx, yy, zz, xy, xz, yz;
  logic signed [MW-1:0] xs_a, ys_a, zs_a;
  logic signed [CW-1:0] c_a, t_a;

  always_ff @(posedge clk) begin
    if (en) begin
      va   <= din.vld;
      xx   <= din.ax * din.ax;
      yy   <= din.ay * din.ay;
      zz   <= din.az * din.az;
      xy   <= din.ax * din.ay;
      xz   <= din.ax * din.az;
      yz   <= din.ay * din.az;
      xs_a <= MW'(din.ax) * MW'(s_in);
      ys_a <= MW'(din.ay) * MW'(s_in);
      zs_a <= MW'(din.az) * MW'(s_in);
      c_a  <= c_in;
      t_a  <= (CW'(1) <<< FRAC_BITS) - c_in;
    end
    if (rst) begin
      va <= 1'b0;
    end
  end

  // Stage B: scale the axis products by one minus cosine and align the sine and cosine terms.
  logic              vb;
  logic signed [MW-1:0] pxx, pyy, pzz, pxy, pxz, pyz, xs_b, ys_b, zs_b, cw_b;

  always_ff @(posedge clk) begin
    if (en) begin
      vb   <= va;
      pxx  <= MW'(xx) * MW'(t_a);
      pyy  <= MW'(yy) * MW'(t_a);
      pzz  <= MW'(zz) * MW'(t_a);
      pxy  <= MW'(xy) * MW'(t_a);
      pxz  <= MW'(xz) * MW'(t_a);
      pyz  <= MW'(yz) * MW'(t_a);
      xs_b <= xs_a <<< 14;
      ys_b <= ys_a <<< 14;
      zs_b <= zs_a <<< 14;
      cw_b <= MW'(c_a) <<< 28;
    end
    if (rst) begin
      vb <= 1'b0;
    end
  end

  // Stage C: sums, rounding to Q2.14 and saturation.
  logic signed [MW-1:0] sum [9];
  logic signed [MW-1:0] rnd [9];
  logic [15:0] sat [9];

  always_comb begin
    sum[0] = pxx + cw_b;
    sum[1] = pxy + zs_b;
    sum[2] = pxz - ys_b;
    sum[3] = pxy - zs_b;
    sum[4] = pyy + cw_b;
    sum[5] = pyz + xs_b;
    sum[6] = pxz + ys_b;
    sum[7] = pyz - xs_b;
    sum[8] = pzz + cw_b;
    for (int k = 0; k < 9; k++) begin
      rnd[k] = (sum[k] + (MW'(1) <<< (RSh - 1))) >>> RSh;
      if (rnd[k] > MW'(32767)) begin
        sat[k] = 16'h7FFF;
      end else if (rnd[k] < -MW'(32768)) begin
        sat[k] = 16'h8000;
      end else begin
        sat[k] = rnd[k][15:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      vld <= vb;
      ent <= sat;
    end
    if (rst) begin
      vld <= 1'b0;
    end
  end

endmodule

// File: rtl/core/arm_row_emit.sv
// Output register that holds one matrix and sends it row by row.
`timescale 1ns / 1ps
module arm_row_emit (
  input  logic        clk,
  input  logic        rst,
  input  logic        load,
  input  logic [15:0] ent [9],
  output logic        can_load,
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [71:0] m_tdata,
  output logic        m_tlast
);

  logic [15:0] mat [9];
  logic [1:0]  row;
  logic        full;
  logic [15:0] e0, e1, e2, e3;

  assign can_load = !full || (m_tready && row == 2'd3);

  // Hold the matrix and step through the rows as each row is taken.
  always_ff @(posedge clk) begin
    if (load) begin
      mat  <= ent;
      row  <= 2'd0;
      full <= 1'b1;
    end else if (full && m_tready) begin
      row <= row + 2'd1;
      if (row == 2'd3) begin
        full <= 1'b0;
      end
    end
    if (rst) begin
      full <= 1'b0;
      row  <= 2'd0;
    end
  end

  // Select the current row; the last row is the homogeneous constant row.
  always_comb begin
    e0 = '0;
    e1 = '0;
    e2 = '0;
    e3 = '0;
    case (row)
      2'd0: begin e0 = mat[0]; e1 = mat[1]; e2 = mat[2]; end
      2'd1: begin e0 = mat[3]; e1 = mat[4]; e2 = mat[5]; end
      2'd2: begin e0 = mat[6]; e1 = mat[7]; e2 = mat[8]; end
      default: e3 = 16'h4000;
    endcase
  end

  assign m_tvalid = full;
  assign m_tdata  = {6'd0, e3, e2, e1, e0, row};
  assign m_tlast  = (row == 2'd3);

endmodule

// File: rtl/core/axis_angle_rotation_matrix.sv
// Top level: axis-angle to 4x4 rotation matrix, CORDIC chain plus matrix pipeline.
`timescale 1ns / 1ps
//  channel | dir | fields (tdata from bit 0 up)
//  s_*     | in  | axis_x[15:0], axis_y[31:16], axis_z[47:32], angle[63:48]
//  m_*     | out | row[1:0], elem0..elem3 (16 bits each) in [65:2], pad; tlast = last
// One request yields four row results, so a finished matrix waits until the last row of the one before is taken.
// The first row of a result passes through the entry register, one CORDIC cell per step,
// three matrix stages and the output register.
// Reset clears only the valid flags of the pipeline and the output row register.
// A stall on the output freezes the whole pipeline once a finished matrix waits.
module axis_angle_rotation_matrix #(
  parameter int CORDIC_STEPS = arm_pkg::CordicSteps,
  parameter int FRAC_BITS    = arm_pkg::FracBits
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [63:0] s_tdata,  // axis_x, axis_y, axis_z, angle
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [71:0] m_tdata,  // row, elem0, elem1, elem2, elem3, zero pad
  output logic        m_tlast
);

  localparam int AW = arm_pkg::AngW;
  localparam logic signed [arm_pkg::CorW-1:0] Gain = arm_pkg::cordic_gain(CORDIC_STEPS);

  logic en;
  logic mat_vld;
  logic can_load;
  logic [15:0] ent [9];

  assign en       = !mat_vld || can_load;
  assign s_tready = en;

  // Range reduction of the angle to [-pi/2, pi/2] with cosine sign flag.
  logic signed [AW-1:0] z0, z1, z2;
  logic neg;
  always_comb begin
    z0 = {s_tdata[63], s_tdata[63:48], 18'd0};
    if (z0 > arm_pkg::Q30Pi) begin
      z1 = z0 - arm_pkg::Q30TwoPi;
    end else if (z0 < -arm_pkg::Q30Pi) begin
      z1 = z0 + arm_pkg::Q30TwoPi;
    end else begin
      z1 = z0;
    end
    neg = 1'b0;
    z2  = z1;
    if (z1 > arm_pkg::Q30HalfPi) begin
      z2  = arm_pkg::Q30Pi - z1;
      neg = 1'b1;
    end else if (z1 < -arm_pkg::Q30HalfPi) begin
      z2  = -arm_pkg::Q30Pi - z1;
      neg = 1'b1;
    end
  end

  arm_pkg::cordic_t chain [CORDIC_STEPS+1];

  // Entry register of the CORDIC chain.
  always_ff @(posedge clk) begin
    if (en) begin
      chain[0].vld <= s_tvalid;
      chain[0].x   <= Gain;
      chain[0].y   <= '0;
      chain[0].z   <= z2[arm_pkg::CorW-1:0];
      chain[0].neg <= neg;
      chain[0].ax  <= s_tdata[15:0];
      chain[0].ay  <= s_tdata[31:16];
      chain[0].az  <= s_tdata[47:32];
    end
    if (rst) begin
      chain[0].vld <= 1'b0;
    end
  end

  for (genvar g = 0; g < CORDIC_STEPS; g++) begin : g_cell
    arm_cordic_cell #(.STEP(g)) u_cell (
      .clk (clk),
      .rst (rst),
      .en  (en),
      .din (chain[g]),
      .dout(chain[g+1])
    );
  end

  arm_matrix #(.FRAC_BITS(FRAC_BITS)) u_matrix (
    .clk(clk),
    .rst(rst),
    .en (en),
    .din(chain[CORDIC_STEPS]),
    .vld(mat_vld),
    .ent(ent)
  );

  arm_row_emit u_emit (
    .clk     (clk),
    .rst     (rst),
    .load    (mat_vld && can_load),
    .ent     (ent),
    .can_load(can_load),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata (m_tdata),
    .m_tlast (m_tlast)
  );

endmodule

// File: test/testbench.sv
// Testbench for the axis-angle rotation matrix builder: directed and random axes and angles.
`timescale 1ns / 1ps

// One expected matrix row, with the fields of one result.
typedef struct {
  logic [1:0]         row;
  logic signed [15:0] elem [4];
  logic               last;
} matrix_row_t;

// Predicts the four rows of each accepted request and checks the rows that come out.
class rotation_board;
  matrix_row_t rows_due[$];
  int          failures = 0;
  longint      gain;

  function new();
    longint unsigned k2;
    longint unsigned rem;
    longint unsigned res;
    longint unsigned bitv;
    k2 = 64'd1 << 30;
    for (int i = 0; i < arm_pkg::CordicSteps; i++) begin
      k2 = k2 - k2 / ((64'd1 << (2 * i)) + 64'd1);
    end
    // Integer square root of k2 scaled to Q60, giving the gain in Q30.
    rem  = k2 << 30;
    res  = 0;
    bitv = 64'd1 << 62;
    while (bitv != 0) begin
      if (rem >= res + bitv) begin
        rem = rem - (res + bitv);
        res = (res >> 1) + bitv;
      end else begin
        res = res >> 1;
      end
      bitv = bitv >> 2;
    end
    gain = longint'(res);
  endfunction

  // Cosine and sine of a Q4.12 angle, rounded to FracBits fraction bits.
  function void sine_cosine(input longint ang, output longint cos_q, output longint sin_q);
    longint zz;
    longint xx;
    longint yy;
    longint dx;
    longint dy;
    longint half;
    bit     flip;
    flip = 0;
    zz   = ang * 262144;
    while (zz > arm_pkg::Q30Pi) zz -= 2 * longint'(arm_pkg::Q30Pi);
    while (zz < -longint'(arm_pkg::Q30Pi)) zz += 2 * longint'(arm_pkg::Q30Pi);
    // Fold the outer quadrants back into the CORDIC range.
    if (zz > arm_pkg::Q30HalfPi) begin
      zz   = longint'(arm_pkg::Q30Pi) - zz;
      flip = 1;
    end else if (zz < -longint'(arm_pkg::Q30HalfPi)) begin
      zz   = -longint'(arm_pkg::Q30Pi) - zz;
      flip = 1;
    end
    xx = gain;
    yy = 0;
    for (int i = 0; i < arm_pkg::CordicSteps; i++) begin
      dx = yy >>> i;
      dy = xx >>> i;
      if (zz >= 0) begin
        xx -= dx;
        yy += dy;
        zz -= longint'(arm_pkg::AtanQ30[i]);
      end else begin
        xx += dx;
        yy -= dy;
        zz += longint'(arm_pkg::AtanQ30[i]);
      end
    end
    if (flip) xx = -xx;
    half  = longint'(1) << (30 - arm_pkg::FracBits - 1);
    cos_q = (xx + half) >>> (30 - arm_pkg::FracBits);
    sin_q = (yy + half) >>> (30 - arm_pkg::FracBits);
  endfunction

  // Round half up to Q2.14 and saturate.
  function logic signed [15:0] to_q14(input longint v);
    longint r;
    int     sh;
    sh = 14 + arm_pkg::FracBits;
    r  = (v + (longint'(1) << (sh - 1))) >>> sh;
    if (r > 32767) r = 32767;
    if (r < -32768) r = -32768;
    return 16'(r);
  endfunction

  function void note_request(input logic [63:0] d);
    longint      ax, ay, az, c, s, t, cw, xs, ys, zs;
    longint      m [3][3];
    matrix_row_t e;
    ax = longint'($signed(d[15:0]));
    ay = longint'($signed(d[31:16]));
    az = longint'($signed(d[47:32]));
    sine_cosine(longint'($signed(d[63:48])), c, s);
    t  = (longint'(1) << arm_pkg::FracBits) - c;
    cw = c * 16384 * 16384;
    xs = ax * s * 16384;
    ys = ay * s * 16384;
    zs = az * s * 16384;
    m[0][0] = ax * ax * t + cw;
    m[0][1] = ay * ax * t + zs;
    m[0][2] = ax * az * t - ys;
    m[1][0] = ax * ay * t - zs;
    m[1][1] = ay * ay * t + cw;
    m[1][2] = ay * az * t + xs;
    m[2][0] = ax * az * t + ys;
    m[2][1] = ay * az * t - xs;
    m[2][2] = az * az * t + cw;
    for (int r = 0; r < 4; r++) begin
      e.row  = 2'(r);
      for (int j = 0; j < 3; j++) e.elem[j] = (r < 3) ? to_q14(m[r][j]) : 16'sd0;
      e.elem[3] = (r < 3) ? 16'sd0 : 16'sd16384;
      e.last = (r == 3);
      rows_due.push_back(e);
    end
  endfunction

  function void check_row(input logic [71:0] d, input logic tl);
    matrix_row_t e;
    logic signed [15:0] got;
    if (rows_due.size() == 0) begin
      $error("unexpected row result %h", d);
      failures++;
      return;
    end
    e = rows_due.pop_front();
    if (d[1:0] !== e.row) begin
      $error("row: expected %0d, got %0d", e.row, d[1:0]);
      failures++;
    end
    for (int j = 0; j < 4; j++) begin
      got = d[2 + 16 * j +: 16];
      if (got !== e.elem[j]) begin
        $error("elem%0d: expected %0d, got %0d", j, e.elem[j], got);
        failures++;
      end
    end
    if (tl !== e.last) begin
      $error("last: expected %0d, got %0d", e.last, tl);
      failures++;
    end
  endfunction
endclass

module testbench;
  logic        clk = 0;
  logic        rst = 1;
  logic        s_tvalid = 0;
  logic        s_tready;
  logic [63:0] s_tdata = '0;
  logic        m_tvalid;
  logic        m_tready = 0;
  logic [71:0] m_tdata;
  logic        m_tlast;
  bit          calm = 0;
  int          quiet_cycles = 0;
  rotation_board board = new();

  localparam int WatchLimit = 5000;

  axis_angle_rotation_matrix dut (.*);

  always begin
    #5 clk = 1;
    #5 clk = 0;
  end

  // Collect rows and stall the output at random.
  always @(posedge clk) begin
    if (!rst) begin
      if (m_tvalid && m_tready) board.check_row(m_tdata, m_tlast);
      m_tready <= calm || ($urandom_range(0, 99) >= 25);
    end
  end

  // Watchdog on cycles where neither side moves a request or a row.
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WatchLimit) begin
      $display("[axis_angle_rotation_matrix] ERROR");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic send_request(input logic signed [15:0] ax, input logic signed [15:0] ay,
                              input logic signed [15:0] az, input logic signed [15:0] ang);
    while (!calm && $urandom_range(0, 99) < 25) begin
      s_tvalid <= 0;
      @(posedge clk);
    end
    s_tvalid <= 1;
    s_tdata  <= {ang, az, ay, ax};
    do @(posedge clk); while (!s_tready);
    board.note_request({ang, az, ay, ax});
  endtask

  // A random unit axis, scaled so that its length is close to one in Q2.14.
  task automatic send_unit_axis(input logic signed [15:0] ang);
    real vx, vy, vz, len;
    vx  = real'($urandom_range(0, 2000)) - 1000.0;
    vy  = real'($urandom_range(0, 2000)) - 1000.0;
    vz  = real'($urandom_range(0, 2000)) - 1000.0;
    len = $sqrt(vx * vx + vy * vy + vz * vz);
    if (len < 1.0) begin
      vx  = 1.0;
      len = 1.0;
    end
    send_request(16'($rtoi(vx / len * 16384.0)), 16'($rtoi(vy / len * 16384.0)),
                 16'($rtoi(vz / len * 16384.0)), ang);
  endtask

  function automatic logic signed [15:0] rand_comp();
    return 16'($urandom_range(0, 32768) - 16384);
  endfunction

  initial begin
    logic signed [15:0] ang;
    repeat (12) @(posedge clk);
    rst <= 0;

    // Directed: unit axes, quadrant edges, full turns and the angle extremes.
    send_request(16384, 0, 0, 0);
    send_request(0, 16384, 0, 6434);
    send_request(0, 0, 16384, -6434);
    send_request(-16384, 0, 0, 12868);
    send_request(0, -16384, 0, -12868);
    send_request(0, 0, -16384, 25736);
    send_request(16384, 0, 0, -25736);
    send_request(0, 0, 16384, 32767);
    send_request(0, 16384, 0, -32768);
    send_request(9459, 9459, 9459, 4289);
    send_request(-9459, 9459, -9459, -10000);
    // Axis far from unit length drives entries into saturation.
    send_request(16384, 16384, 16384, 12868);
    send_request(-16384, -16384, -16384, 12868);
    send_request(16384, -16384, 16384, 6434);
    send_request(0, 0, 0, 3000);
    send_request(-1, -1, -1, -1);
    send_request(1, 1, 1, 1);
    send_request(11585, 0, -11585, 8000);

    // Random: mostly unit axes, a fifth arbitrary, with a calm stretch in the middle.
    for (int n = 0; n < 470; n++) begin
      calm = (n >= 200 && n < 280);
      if ($urandom_range(0, 9) == 0) ang = 16'($urandom());
      else ang = 16'($urandom_range(0, 51472) - 25736);
      if ($urandom_range(0, 4) == 0) send_request(rand_comp(), rand_comp(), rand_comp(), ang);
      else send_unit_axis(ang);
    end
    s_tvalid <= 0;
    calm = 0;

    while (board.rows_due.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (board.failures == 0 && board.rows_due.size() == 0) begin
      $display("[axis_angle_rotation_matrix] OK");
    end else begin
      $display("[axis_angle_rotation_matrix] ERROR");
    end
    $finish;
  end
endmodule

// File: axis_angle_rotation_matrix.f
rtl/core/arm_pkg.sv
rtl/core/arm_cordic_cell.sv
rtl/core/arm_matrix.sv
rtl/core/arm_row_emit.sv
rtl/core/axis_angle_rotation_matrix.sv
test/testbench.sv
